/* rtl/bal_pkg.sv */
// Shared types, constants and helpers for the bounded array list unit.
// Depends on nothing; the engine and top level refer to it by scoped names, the testbench imports it.
package bal_pkg;

    // Storage geometry
    localparam int MAX_DEPTH = 64;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int POS_W     = 7;
    localparam int CAP_W     = 7;
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int WORD_W    = 32;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Operation codes
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_EDIT   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    // Register index of the capacity register
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [2:0]              operation;
        logic [POS_W-1:0]        position;
        logic signed [WORD_W-1:0] word_in;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [WORD_W-1:0] read_value;
        logic [6:0]              entry_count;
        logic                    is_full;
        logic                    is_empty;
    } rsp_t;

    // Configuration seen by the list engine
    typedef struct packed {
        logic             clear;
        logic [CNT_W-1:0] capacity;
    } cfg_t;

    // Map a written capacity onto 1..MAX_DEPTH
    function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (CMP_W'(v) > CMP_W'(MAX_DEPTH))
            r = CNT_W'(MAX_DEPTH);
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage

/* rtl/bounded_array_list_unit.sv */
// Top level of the bounded array list unit: APB capacity register and the
// list engine with its entry RAM.
// Depends on bal_pkg and bal_engine.
//
// Usage:
//   Request channel (req_valid/req_ready/req) carries one operation word:
//   append, insert, delete, edit or read. Response channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one word per request with the
//   status, the value read (-1 otherwise), the entry count and full/empty.
//   Requests are handled one at a time; the next word is accepted only after
//   the response of the last one is loaded. Rejected requests, unused codes
//   and a delete of the last entry go straight to the response; append, edit
//   and read pass one RAM access first; insert and delete first shift the
//   entries between the position and the end, since the entry RAM moves one
//   entry per cycle through its single write port. The worst case is an
//   insert at the front of 63 entries.
//   Reset empties the list and sets the capacity to 64 (clamped to the
//   storage depth); the entries themselves are not cleared.
//   A write to the capacity register (address 0) clamps the value to
//   1..depth and empties the list; write it only while the unit is idle.
//   A stalled response is held in the output register; the next request is
//   still accepted and processed, and waits at its end for the register.
module bounded_array_list_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  bal_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output bal_pkg::rsp_t                 rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bal_pkg::PADDR_W-1:0]   paddr,
    input  logic [bal_pkg::PDATA_W-1:0]   pwdata,
    output logic [bal_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [bal_pkg::CNT_W-1:0] cap_reg, cap_next;
    logic                      cap_write;
    bal_pkg::cfg_t             cfg;

    assign pready    = 1'b1;
    assign cap_write = psel && penable && pwrite && (paddr[2] == bal_pkg::REG_CAPACITY);

    // Clamp the written capacity
    always_comb
    begin
        cap_next = cap_reg;
        if (cap_write)
            cap_next = bal_pkg::clamp_cap(pwdata[bal_pkg::CAP_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= bal_pkg::clamp_cap(bal_pkg::CAP_W'(64));
        else
            cap_reg <= cap_next;
    end

    // Read back the capacity; other addresses read zero
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == bal_pkg::REG_CAPACITY)
            prdata = bal_pkg::PDATA_W'(cap_reg);
    end

    assign cfg.clear    = cap_write;
    assign cfg.capacity = cap_reg;

    bal_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* rtl/bal_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
module bal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/bal_engine.sv */
// List sequencer: checks each request, shifts entries through the entry RAM
// one per cycle, keeps the fill count and drives the response register.
// Depends on bal_pkg and bal_ram.
module bal_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  bal_pkg::cfg_t cfg,
    input  logic          req_valid,
    output logic          req_ready,
    input  bal_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bal_pkg::rsp_t rsp
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WRITE  = 6'b000010,
        S_PRIME  = 6'b000100,
        S_SHIFT  = 6'b001000,
        S_RDWAIT = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [bal_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [bal_pkg::ADDR_W-1:0]      ptr_reg, ptr_next;
    logic [2:0]                      op_reg, op_next;
    logic [bal_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [bal_pkg::WORD_W-1:0]      word_reg, word_next;
    logic [1:0]                      status_reg, status_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    bal_pkg::rsp_t                   rsp_reg, rsp_next;

    logic                            ram_we, ram_re;
    logic [bal_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [bal_pkg::WORD_W-1:0]      ram_wdata, ram_rdata;

    logic                            accept, full;
    logic [bal_pkg::CMP_W-1:0]       pos_c, cnt_c, ptr_c, posr_c;
    logic [1:0]                      chk_status;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign full   = (count_reg >= cfg.capacity);
    assign pos_c  = bal_pkg::CMP_W'(req.position);
    assign posr_c = bal_pkg::CMP_W'(pos_reg);
    assign cnt_c  = bal_pkg::CMP_W'(count_reg);
    assign ptr_c  = bal_pkg::CMP_W'(ptr_reg);

    // Check the incoming request; a bad index outranks overflow
    always_comb
    begin
        chk_status = bal_pkg::ST_OK;
        case (req.operation)
            bal_pkg::OP_APPEND:
            begin
                if (full)
                    chk_status = bal_pkg::ST_OVERFLOW;
            end
            bal_pkg::OP_INSERT:
            begin
                if (pos_c > cnt_c)
                    chk_status = bal_pkg::ST_BAD_INDEX;
                else if (full)
                    chk_status = bal_pkg::ST_OVERFLOW;
            end
            bal_pkg::OP_DELETE, bal_pkg::OP_EDIT, bal_pkg::OP_READ:
            begin
                if (pos_c >= cnt_c)
                    chk_status = bal_pkg::ST_BAD_INDEX;
            end
            default:
            begin
                chk_status = bal_pkg::ST_OK;
            end
        endcase
    end

    // Sequence one request: check, shift, write, report
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        word_next      = word_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg;
        ram_wdata      = word_reg;
        ram_re         = 1'b0;
        ram_raddr      = ptr_reg;

        // Drop the response once taken
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.operation;
                    pos_next    = req.position;
                    word_next   = req.word_in;
                    status_next = chk_status;
                    state_next  = S_DONE;
                    if (chk_status == bal_pkg::ST_OK)
                    begin
                        case (req.operation)
                            bal_pkg::OP_APPEND:
                            begin
                                ptr_next   = bal_pkg::ADDR_W'(count_reg);
                                state_next = S_WRITE;
                            end
                            bal_pkg::OP_EDIT:
                            begin
                                ptr_next   = bal_pkg::ADDR_W'(req.position);
                                state_next = S_WRITE;
                            end
                            bal_pkg::OP_READ:
                            begin
                                state_next = S_RDWAIT;
                            end
                            bal_pkg::OP_INSERT:
                            begin
                                if (pos_c == cnt_c)
                                begin
                                    ptr_next   = bal_pkg::ADDR_W'(req.position);
                                    state_next = S_WRITE;
                                end
                                else
                                begin
                                    ptr_next   = bal_pkg::ADDR_W'(count_reg);
                                    state_next = S_PRIME;
                                end
                            end
                            bal_pkg::OP_DELETE:
                            begin
                                // Last entry goes without a shift
                                if (pos_c + bal_pkg::CMP_W'(1) == cnt_c)
                                    count_next = count_reg - bal_pkg::CNT_W'(1);
                                else
                                begin
                                    ptr_next   = bal_pkg::ADDR_W'(req.position);
                                    state_next = S_PRIME;
                                end
                            end
                            default:
                            begin
                                state_next = S_DONE;
                            end
                        endcase
                    end
                end
            end

            S_PRIME:
            begin
                // Fetch the first neighbor to move
                ram_re = 1'b1;
                if (op_reg == bal_pkg::OP_INSERT)
                    ram_raddr = ptr_reg - bal_pkg::ADDR_W'(1);
                else
                    ram_raddr = ptr_reg + bal_pkg::ADDR_W'(1);
                state_next = S_SHIFT;
            end

            S_SHIFT:
            begin
                // Move one entry; the next read is two away from the write
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (op_reg == bal_pkg::OP_INSERT)
                begin
                    if (ptr_c - bal_pkg::CMP_W'(1) == posr_c)
                    begin
                        ptr_next   = bal_pkg::ADDR_W'(pos_reg);
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = ptr_reg - bal_pkg::ADDR_W'(2);
                        ptr_next   = ptr_reg - bal_pkg::ADDR_W'(1);
                    end
                end
                else
                begin
                    if (ptr_c + bal_pkg::CMP_W'(2) == cnt_c)
                    begin
                        count_next = count_reg - bal_pkg::CNT_W'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = ptr_reg + bal_pkg::ADDR_W'(2);
                        ptr_next   = ptr_reg + bal_pkg::ADDR_W'(1);
                    end
                end
            end

            S_WRITE:
            begin
                // Store the request word; append and insert grow the list
                ram_we = 1'b1;
                if (op_reg != bal_pkg::OP_EDIT)
                    count_next = count_reg + bal_pkg::CNT_W'(1);
                state_next = S_DONE;
            end

            S_RDWAIT:
            begin
                ram_re     = 1'b1;
                ram_raddr  = bal_pkg::ADDR_W'(pos_reg);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Load the response register when it is free or being taken
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.read_value  = '1;
                    if (op_reg == bal_pkg::OP_READ && status_reg == bal_pkg::ST_OK)
                        rsp_next.read_value = ram_rdata;
                    rsp_next.entry_count = 7'(count_reg);
                    rsp_next.is_full     = (count_reg >= cfg.capacity);
                    rsp_next.is_empty    = (count_reg == '0);
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A capacity write empties the list
        if (cfg.clear)
            count_next = '0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        word_reg   <= word_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    bal_ram #(
        .WIDTH (bal_pkg::WORD_W),
        .DEPTH (bal_pkg::MAX_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The list never holds more than the capacity allows
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cfg.capacity)
        else $error("fill count above capacity");

    // A shift never reads the entry it writes in the same cycle
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("shift read and write hit the same entry");

    // Shifting starts only after the first neighbor was fetched
    a_shift_primed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> ($past(state_reg) == S_PRIME || $past(state_reg) == S_SHIFT))
        else $error("shift without a primed read");

endmodule

/* tb/bounded_array_list_unit_tb.sv */
// Self-checking testbench for bounded_array_list_unit: drives list operations
// and capacity writes, and predicts each response word with a shadow list.
// Depends on bal_pkg and the bounded_array_list_unit RTL.
module bounded_array_list_unit_tb;
    import bal_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * REG_CAPACITY);
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    // Shadow copy of the list
    logic [WORD_W-1:0] list_entries [0:MAX_DEPTH-1];
    int unsigned list_count = 0;
    int unsigned list_capacity = MAX_DEPTH;

    req_t list_ops_q [$];
    rsp_t list_results_q [$];

    logic req_fired = 1'b0;
    bit idle_enable = 1'b1;
    int send_gap = 0;
    int rsp_gap = 0;
    int long_stall_req = 0;
    int long_stall_left = 0;
    bit long_stall_taken = 1'b0;
    int error_count = 0;
    int cycle_count = 0;

    bounded_array_list_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Map a written capacity onto the usable range
    function automatic int unsigned effective_capacity(input logic [6:0] written);
        int unsigned v;
        v = written;
        if (v == 0)
            v = 1;
        else if (v > MAX_DEPTH)
            v = MAX_DEPTH;
        return v;
    endfunction

    // Apply one operation to the shadow list and build the response word
    function automatic rsp_t apply_list_op(input req_t op_word);
        rsp_t res;
        int unsigned pos;
        bit at_limit;
        pos = op_word.position;
        at_limit = (list_count >= list_capacity);
        res.status = ST_OK;
        res.read_value = '1;
        case (op_word.operation)
            OP_APPEND:
            begin
                if (at_limit)
                    res.status = ST_OVERFLOW;
                else
                begin
                    list_entries[list_count] = op_word.word_in;
                    list_count++;
                end
            end
            OP_INSERT:
            begin
                if (pos > list_count)
                    res.status = ST_BAD_INDEX;
                else if (at_limit)
                    res.status = ST_OVERFLOW;
                else
                begin
                    for (int i = list_count; i > pos; i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[pos] = op_word.word_in;
                    list_count++;
                end
            end
            OP_DELETE:
            begin
                if (pos >= list_count)
                    res.status = ST_BAD_INDEX;
                else
                begin
                    for (int i = pos; i + 1 < list_count; i++)
                        list_entries[i] = list_entries[i+1];
                    list_count--;
                end
            end
            OP_EDIT:
            begin
                if (pos >= list_count)
                    res.status = ST_BAD_INDEX;
                else
                    list_entries[pos] = op_word.word_in;
            end
            OP_READ:
            begin
                if (pos >= list_count)
                    res.status = ST_BAD_INDEX;
                else
                    res.read_value = list_entries[pos];
            end
            default:
            begin
            end
        endcase
        res.entry_count = 7'(list_count);
        res.is_full = (list_count >= list_capacity);
        res.is_empty = (list_count == 0);
        return res;
    endfunction

    // Queue one operation word for the driver
    task automatic add_op(input logic [2:0] op, input logic [6:0] pos, input logic [31:0] data);
        req_t w;
        w.operation = op;
        w.position = pos;
        w.word_in = data;
        list_ops_q.push_back(w);
    endtask

    // Pick a data value, leaning on the extremes now and then
    function automatic logic [31:0] pick_word();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h0000_0000;
            3: v = 32'hFFFF_FFFF;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Queue a random operation; grow_pct sets the share of append and insert
    task automatic add_random_op(input int unsigned cap, input int unsigned grow_pct);
        logic [2:0] op;
        logic [6:0] pos;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < grow_pct)
            op = (roll < grow_pct / 2) ? OP_APPEND : OP_INSERT;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                op = OP_DELETE;
            else if (roll < 55)
                op = OP_EDIT;
            else if (roll < 95)
                op = OP_READ;
            else
                op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        if ($urandom_range(0, 9) == 0)
            pos = 7'($urandom_range(0, 127));
        else
            pos = 7'($urandom_range(0, cap));
        add_op(op, pos, pick_word());
    endtask

    // Wait until every queued word has gone through and been answered
    task automatic wait_idle();
        while (list_ops_q.size() != 0 || req_valid || list_results_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the capacity register over a setup and an access cycle
    task automatic write_capacity(input logic [6:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        list_capacity = effective_capacity(value);
        list_count = 0;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Settle, set a new capacity and queue a burst of random words
    task automatic run_phase(input logic [6:0] cap_value, input int items,
                             input int unsigned grow_pct);
        wait_idle();
        write_capacity(cap_value);
        repeat (items) add_random_op(effective_capacity(cap_value), grow_pct);
    endtask

    // Driver: hold a word until taken, then idle or offer the next one
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!(req_valid && !req_fired))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(1, 18) - 1;
                req_valid <= 1'b0;
            end
            else if (list_ops_q.size() != 0)
            begin
                req <= list_ops_q.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver: one long hold-off on request, otherwise random stall bursts
    always @(negedge clk)
    begin
        if (!long_stall_taken && long_stall_req != 0)
        begin
            long_stall_left = long_stall_req;
            long_stall_taken = 1'b1;
        end
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (long_stall_left > 0)
        begin
            long_stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (rsp_gap > 0)
        begin
            rsp_gap--;
            rsp_ready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            rsp_gap = $urandom_range(1, 18) - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Monitor: check the response word first, then predict the accepted one
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (list_results_q.size() == 0)
            begin
                $error("response word with nothing pending: %p", rsp);
                error_count++;
            end
            else
            begin
                want = list_results_q.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d", want.read_value,
                           rsp.read_value);
                    error_count++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           rsp.entry_count);
                    error_count++;
                end
                if (rsp.is_full !== want.is_full)
                begin
                    $error("is_full: expected %0d, got %0d", want.is_full, rsp.is_full);
                    error_count++;
                end
                if (rsp.is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, rsp.is_empty);
                    error_count++;
                end
            end
        end
        if (rst_n && req_valid && req_ready)
            list_results_q.push_back(apply_list_op(req));
        req_fired <= rst_n && req_valid && req_ready;
    end

    // Give up if the run hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL bounded_array_list_unit");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty list at the reset capacity: every indexed access is rejected
        add_op(OP_READ, 7'd0, 32'h1234_5678);
        add_op(OP_DELETE, 7'd0, 32'h0);
        add_op(OP_EDIT, 7'd0, 32'hFFFF_FFFF);
        add_op(OP_INSERT, 7'd1, 32'h5555_5555);
        // Fill a few entries with extreme values
        add_op(OP_INSERT, 7'd0, 32'h8000_0000);
        add_op(OP_APPEND, 7'd127, 32'h7FFF_FFFF);
        add_op(OP_APPEND, 7'd0, 32'h0000_0000);
        add_op(OP_APPEND, 7'd64, 32'hFFFF_FFFF);
        add_op(OP_INSERT, 7'd127, 32'hAAAA_AAAA);
        add_op(OP_READ, 7'd0, 32'h0);
        add_op(OP_READ, 7'd3, 32'h0);
        add_op(OP_EDIT, 7'd3, 32'h5A5A_A5A5);
        add_op(OP_DELETE, 7'd4, 32'h0);
        add_op(OP_DELETE, 7'd0, 32'h0);
        add_op(OP_READ, 7'd0, 32'h0);
        add_op(OP_INSERT, 7'd3, 32'h0F0F_F0F0);
        add_op(OP_READ, 7'd127, 32'h0);
        add_op(OP_UNUSED_LO, 7'd127, 32'hFFFF_FFFF);
        add_op(3'd6, 7'd0, 32'h8000_0000);
        add_op(OP_UNUSED_HI, 7'd64, 32'h7FFF_FFFF);
        wait_idle();

        // Tiny capacity: overflow, and bad index winning over overflow
        write_capacity(7'd2);
        add_op(OP_APPEND, 7'd0, 32'h1111_1111);
        add_op(OP_APPEND, 7'd0, 32'h2222_2222);
        add_op(OP_APPEND, 7'd0, 32'h3333_3333);
        add_op(OP_INSERT, 7'd0, 32'h4444_4444);
        add_op(OP_INSERT, 7'd3, 32'h5555_5555);
        add_op(OP_DELETE, 7'd1, 32'h0);
        add_op(OP_READ, 7'd0, 32'h0);

        // Random phases across the capacity range
        run_phase(7'd0, 40, 50);
        run_phase(7'd1, 40, 50);
        run_phase(7'd127, 150, 70);
        long_stall_req = 300;
        run_phase(7'd64, 80, 45);
        run_phase(7'($urandom_range(3, 63)), 70, 55);
        run_phase(7'($urandom_range(65, 126)), 40, 60);
        wait_idle();
        idle_enable = 1'b0;
        run_phase(7'd8, 70, 50);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS bounded_array_list_unit");
        else
            $display("FAIL bounded_array_list_unit");
        $finish;
    end

endmodule
